>>> sv/isoep_pkg.sv
// Shared constants and the month table for the timestamp-to-epoch converter.
`default_nettype none
package isoep_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned FIELD_W = 7;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned DAYS_W  = 24;
    localparam int unsigned HMS_W   = 19;

    localparam logic [POS_W-1:0] FULL_LEN = 5'd19;

    // Character positions where each numeric field starts.
    localparam logic [POS_W-1:0] POS_YEAR   = 5'd0;
    localparam logic [POS_W-1:0] POS_MONTH  = 5'd5;
    localparam logic [POS_W-1:0] POS_DAY    = 5'd8;
    localparam logic [POS_W-1:0] POS_HOUR   = 5'd11;
    localparam logic [POS_W-1:0] POS_MINUTE = 5'd14;
    localparam logic [POS_W-1:0] POS_SECOND = 5'd17;

    localparam logic [YEAR_W-1:0] EARLIEST_RESET = 14'd2020;
    localparam logic [YEAR_W-1:0] YEAR_EPOCH     = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_LEAP4     = 14'd1969;
    localparam logic [YEAR_W-1:0] YEAR_LEAP100   = 14'd1901;
    localparam logic [YEAR_W-1:0] YEAR_LEAP400   = 14'd1601;

    // ceil(2^20/100) == ceil(2^22/400); exact for operands below 43690.
    localparam logic [13:0] RECIP_100 = 14'd10486;
    localparam int unsigned SHIFT_100 = 20;
    localparam int unsigned SHIFT_400 = 22;

    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    function automatic logic [8:0] days_before_month(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

>>> sv/iso8601_timestamp_to_epoch.sv
// Top level: character parser and pipelined epoch arithmetic.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------
//  input    | i_in_valid / o_in_ready    | i_text_char, i_last_char
//  result   | o_out_valid / i_out_ready  | o_epoch_seconds, o_ok
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (earliest year)
//
// One character is taken per cycle unless stalled. A beat with the last-character
// mark yields its result through one parse register and four arithmetic stages
// (signed offsets, constant multiplies, day sum, seconds multiply).
// Reset clears the parser and the pipeline and sets the earliest year to 2020.
// A stalled result holds the pipeline; bubbles between results are squeezed out.
`default_nettype none
module iso8601_timestamp_to_epoch
    import isoep_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_text_char,
    input  wire logic               i_last_char,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [31:0]             o_epoch_seconds,
    output logic                    o_ok,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [YEAR_W-1:0]  i_cfg_data
);

    typedef logic [FIELD_W-1:0] t_field;

    // ---------------- configuration ----------------
    logic [YEAR_W-1:0] r_earliest;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_earliest <= EARLIEST_RESET;
        end else if (i_cfg_valid) begin
            r_earliest <= i_cfg_data;
        end
    end

    // ---------------- stage enables ----------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_o_valid;
    logic en_a, en_b, en_c, en_d, en_o;
    logic in_fire;

    assign en_o       = !r_o_valid || i_out_ready;
    assign en_d       = !r_d_valid || en_o;
    assign en_c       = !r_c_valid || en_d;
    assign en_b       = !r_b_valid || en_c;
    assign en_a       = !r_a_valid || en_b;
    assign o_in_ready = en_a;
    assign in_fire    = i_in_valid && en_a;

    // ---------------- character parser ----------------
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [YEAR_W-1:0] r_year, n_year;
    t_field            r_month, n_month, r_day, n_day;
    t_field            r_hour, n_hour, r_min, n_min, r_sec, n_sec;
    logic              r_ended, n_ended;

    logic              is_digit, field_start, in_field, ended_eff, take;
    logic [3:0]        digit;
    logic [17:0]       year_x10;
    logic [10:0]       fld_x10;
    t_field            fld_cur, fld_new;

    always_comb begin
        is_digit    = (i_text_char >= CHAR_ZERO) && (i_text_char <= CHAR_NINE);
        digit       = 4'(i_text_char - CHAR_ZERO);
        field_start = (r_pos == POS_YEAR) || (r_pos == POS_MONTH) || (r_pos == POS_DAY)
                   || (r_pos == POS_HOUR) || (r_pos == POS_MINUTE)
                   || (r_pos == POS_SECOND);
        in_field    = (r_pos < POS_YEAR + 5'd4)
                   || (r_pos == POS_MONTH)  || (r_pos == POS_MONTH + 5'd1)
                   || (r_pos == POS_DAY)    || (r_pos == POS_DAY + 5'd1)
                   || (r_pos == POS_HOUR)   || (r_pos == POS_HOUR + 5'd1)
                   || (r_pos == POS_MINUTE) || (r_pos == POS_MINUTE + 5'd1)
                   || (r_pos == POS_SECOND) || (r_pos == POS_SECOND + 5'd1);
        ended_eff   = field_start ? 1'b0 : r_ended;
        take        = in_field && !ended_eff && is_digit;
        n_ended     = ended_eff || (in_field && !is_digit);

        case (r_pos)
            POS_MONTH, POS_MONTH + 5'd1:   fld_cur = r_month;
            POS_DAY, POS_DAY + 5'd1:       fld_cur = r_day;
            POS_HOUR, POS_HOUR + 5'd1:     fld_cur = r_hour;
            POS_MINUTE, POS_MINUTE + 5'd1: fld_cur = r_min;
            POS_SECOND, POS_SECOND + 5'd1: fld_cur = r_sec;
            default:                       fld_cur = r_month;
        endcase

        year_x10 = ({4'd0, r_year} << 3) + ({4'd0, r_year} << 1) + {14'd0, digit};
        fld_x10  = ({4'd0, fld_cur} << 3) + ({4'd0, fld_cur} << 1) + {7'd0, digit};
        fld_new  = fld_x10[FIELD_W-1:0];

        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        if (take) begin
            case (r_pos)
                POS_MONTH, POS_MONTH + 5'd1:   n_month = fld_new;
                POS_DAY, POS_DAY + 5'd1:       n_day   = fld_new;
                POS_HOUR, POS_HOUR + 5'd1:     n_hour  = fld_new;
                POS_MINUTE, POS_MINUTE + 5'd1: n_min   = fld_new;
                POS_SECOND, POS_SECOND + 5'd1: n_sec   = fld_new;
                default:                       n_year  = year_x10[YEAR_W-1:0];
            endcase
        end

        n_pos = (r_pos < FULL_LEN) ? r_pos + 5'd1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_year  <= '0;
            r_month <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_ended <= 1'b0;
        end else if (in_fire) begin
            // drop the parse state once the timestamp closes
            if (i_last_char) begin
                r_pos   <= '0;
                r_year  <= '0;
                r_month <= '0;
                r_day   <= '0;
                r_hour  <= '0;
                r_min   <= '0;
                r_sec   <= '0;
                r_ended <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_year  <= n_year;
                r_month <= n_month;
                r_day   <= n_day;
                r_hour  <= n_hour;
                r_min   <= n_min;
                r_sec   <= n_sec;
                r_ended <= n_ended;
            end
        end
    end

    // ---------------- stage A: captured fields ----------------
    logic [YEAR_W-1:0] r_a_year;
    t_field            r_a_month, r_a_day, r_a_hour, r_a_min, r_a_sec;
    logic              r_a_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= in_fire && i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_year  <= n_year;
            r_a_month <= n_month;
            r_a_day   <= n_day;
            r_a_hour  <= n_hour;
            r_a_min   <= n_min;
            r_a_sec   <= n_sec;
            r_a_full  <= (n_pos == FULL_LEN);
        end
    end

    // ---------------- stage B: checks and signed offsets ----------------
    logic              r_b_ok;
    logic [YEAR_W-1:0] r_b_year, r_b_abs4, r_b_abs100, r_b_abs400;
    logic              r_b_neg4, r_b_neg100, r_b_neg400;
    logic [14:0]       r_b_yoff;
    t_field            r_b_month, r_b_day, r_b_hour, r_b_min, r_b_sec;

    logic              b_ok;
    logic [14:0]       b_d4, b_d100, b_d400;

    always_comb begin
        b_ok = r_a_full && (r_a_year >= r_earliest)
            && (r_a_month >= 7'd1) && (r_a_month <= 7'd12)
            && (r_a_day >= 7'd1) && (r_a_day <= 7'd31);
        b_d4   = {1'b0, r_a_year} - {1'b0, YEAR_LEAP4};
        b_d100 = {1'b0, r_a_year} - {1'b0, YEAR_LEAP100};
        b_d400 = {1'b0, r_a_year} - {1'b0, YEAR_LEAP400};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_ok     <= b_ok;
            r_b_year   <= r_a_year;
            r_b_yoff   <= {1'b0, r_a_year} - {1'b0, YEAR_EPOCH};
            r_b_neg4   <= b_d4[14];
            r_b_neg100 <= b_d100[14];
            r_b_neg400 <= b_d400[14];
            r_b_abs4   <= b_d4[14]   ? YEAR_W'(-b_d4)   : b_d4[YEAR_W-1:0];
            r_b_abs100 <= b_d100[14] ? YEAR_W'(-b_d100) : b_d100[YEAR_W-1:0];
            r_b_abs400 <= b_d400[14] ? YEAR_W'(-b_d400) : b_d400[YEAR_W-1:0];
            r_b_month  <= r_a_month;
            r_b_day    <= r_a_day;
            r_b_hour   <= r_a_hour;
            r_b_min    <= r_a_min;
            r_b_sec    <= r_a_sec;
        end
    end

    // ---------------- stage C: constant multiplies ----------------
    logic              r_c_ok;
    logic [YEAR_W-1:0] r_c_year;
    logic [11:0]       r_c_q4;
    logic [7:0]        r_c_q100, r_c_uq100;
    logic [5:0]        r_c_q400, r_c_uq400;
    logic              r_c_neg4, r_c_neg100, r_c_neg400;
    logic [DAYS_W-1:0] r_c_yd;
    logic [8:0]        r_c_mdays;
    logic              r_c_after_feb;
    t_field            r_c_day, r_c_sec;
    logic [18:0]       r_c_hsec;
    logic [12:0]       r_c_msec;

    logic [27:0]       c_p100, c_p400, c_pyear;
    logic signed [24:0] c_yd;
    logic [3:0]        c_midx;

    always_comb begin
        c_p100  = r_b_abs100 * RECIP_100;
        c_p400  = r_b_abs400 * RECIP_100;
        c_pyear = r_b_year * RECIP_100;
        c_yd    = $signed(r_b_yoff) * $signed({1'b0, DAYS_PER_YEAR});
        c_midx  = r_b_month[3:0] - 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_ok        <= r_b_ok;
            r_c_year      <= r_b_year;
            r_c_q4        <= r_b_abs4[YEAR_W-1:2];
            r_c_q100      <= c_p100[SHIFT_100 +: 8];
            r_c_q400      <= c_p400[SHIFT_400 +: 6];
            r_c_uq100     <= c_pyear[SHIFT_100 +: 8];
            r_c_uq400     <= c_pyear[SHIFT_400 +: 6];
            r_c_neg4      <= r_b_neg4;
            r_c_neg100    <= r_b_neg100;
            r_c_neg400    <= r_b_neg400;
            r_c_yd        <= c_yd[DAYS_W-1:0];
            r_c_mdays     <= days_before_month(c_midx);
            r_c_after_feb <= (r_b_month > 7'd2);
            r_c_day       <= r_b_day;
            r_c_sec       <= r_b_sec;
            r_c_hsec      <= r_b_hour * SEC_PER_HOUR;
            r_c_msec      <= r_b_min * SEC_PER_MIN;
        end
    end

    // ---------------- stage D: day count ----------------
    logic              r_d_ok;
    logic [DAYS_W-1:0] r_d_days;
    logic [HMS_W-1:0]  r_d_hms;

    logic              d_leap;
    logic [14:0]       d_m100, d_m400;
    logic [DAYS_W-1:0] d_t4, d_t100, d_t400, d_days;

    always_comb begin
        d_m100 = r_c_uq100 * 7'd100;
        d_m400 = r_c_uq400 * 9'd400;
        d_leap = (r_c_year[1:0] == 2'd0)
              && ((d_m100 != {1'b0, r_c_year}) || (d_m400 == {1'b0, r_c_year}));
        d_t4   = {12'd0, r_c_q4};
        d_t100 = {16'd0, r_c_q100};
        d_t400 = {18'd0, r_c_q400};
        // quotients truncate toward zero below the reference years
        if (r_c_neg4)   d_t4   = -d_t4;
        if (r_c_neg100) d_t100 = -d_t100;
        if (r_c_neg400) d_t400 = -d_t400;
        d_days = r_c_yd + d_t4 - d_t100 + d_t400 + {15'd0, r_c_mdays}
               + {23'd0, d_leap && r_c_after_feb} + {17'd0, r_c_day} - 24'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en_d) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_ok   <= r_c_ok;
            r_d_days <= d_days;
            r_d_hms  <= r_c_hsec + {6'd0, r_c_msec} + {12'd0, r_c_sec};
        end
    end

    // ---------------- stage E: seconds and result register ----------------
    logic [31:0] r_o_epoch;
    logic        r_o_ok;
    logic [48:0] e_prod;
    logic [31:0] e_epoch;

    always_comb begin
        e_prod  = {{8{r_d_days[DAYS_W-1]}}, r_d_days} * SEC_PER_DAY;
        e_epoch = e_prod[31:0] + {13'd0, r_d_hms};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_ok    <= r_d_ok;
            r_o_epoch <= r_d_ok ? e_epoch : 32'd0;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_epoch_seconds = r_o_epoch;
    assign o_ok            = r_o_ok;

endmodule
`default_nettype wire

>>> tb/iso8601_timestamp_to_epoch_tb.sv
// Testbench for the timestamp-to-epoch converter: directed and random text, scoreboard check.
`default_nettype none
module iso8601_timestamp_to_epoch_tb;
    import isoep_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [31:0] secs;
        logic        ok;
    } t_epoch;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_text_char;
    logic              i_last_char;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [31:0]       o_epoch_seconds;
    logic              o_ok;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [YEAR_W-1:0] i_cfg_data;

    iso8601_timestamp_to_epoch u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_text_char     (i_text_char),
        .i_last_char     (i_last_char),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_epoch_seconds (o_epoch_seconds),
        .o_ok            (o_ok),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    t_epoch     expected_epochs[$];
    t_epoch     want_epoch;
    logic [7:0] text_buf[$];

    // Shadow parser state and the earliest-year register.
    logic [POS_W-1:0]   sh_pos;
    logic [YEAR_W-1:0]  sh_year;
    logic [YEAR_W-1:0]  sh_earliest;
    logic [FIELD_W-1:0] sh_month;
    logic [FIELD_W-1:0] sh_day;
    logic [FIELD_W-1:0] sh_hour;
    logic [FIELD_W-1:0] sh_minute;
    logic [FIELD_W-1:0] sh_second;
    logic               sh_ended;

    int err_count;
    int stamps_sent;
    int results_seen;
    int ok_seen;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check each result beat against the oldest prediction, then pick next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_epochs.size() == 0) begin
                $error("unexpected result: epoch_seconds %0d ok %0b", o_epoch_seconds, o_ok);
                err_count++;
            end else begin
                want_epoch = expected_epochs.pop_front();
                if (o_epoch_seconds !== want_epoch.secs) begin
                    $error("epoch_seconds: expected %0d, got %0d", want_epoch.secs,
                           o_epoch_seconds);
                    err_count++;
                end
                if (o_ok !== want_epoch.ok) begin
                    $error("ok: expected %0b, got %0b", want_epoch.ok, o_ok);
                    err_count++;
                end
                if (o_ok === 1'b1) ok_seen++;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int month_len(int m);
        case (m)
            2:           return 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic logic [31:0] stamp_seconds();
        longint y;
        longint days;
        longint total;
        bit     leap;
        y    = longint'(sh_year);
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        days = (y - 1970) * 365 + (y - 1969) / 4 - (y - 1901) / 100 + (y - 1601) / 400;
        for (int m = 1; m < int'(sh_month); m++) days += month_len(m);
        if (leap && sh_month > 2) days += 1;
        days += longint'(sh_day) - 1;
        total = days * 86400 + longint'(sh_hour) * 3600 + longint'(sh_minute) * 60
              + longint'(sh_second);
        return total[31:0];
    endfunction

    task automatic clear_fields();
        sh_pos    = '0;
        sh_year   = '0;
        sh_month  = '0;
        sh_day    = '0;
        sh_hour   = '0;
        sh_minute = '0;
        sh_second = '0;
        sh_ended  = 1'b0;
    endtask

    // Advance the shadow parser by one accepted character.
    task automatic parse_char(input logic [7:0] c, input logic is_last);
        logic [POS_W-1:0] p;
        logic [3:0]       dv;
        bit               in_field;
        t_epoch           res;
        p  = sh_pos;
        dv = c[3:0];
        in_field = (p <= 3) || p == 5 || p == 6 || p == 8 || p == 9 || p == 11 || p == 12
                || p == 14 || p == 15 || p == 17 || p == 18;
        if (p == POS_YEAR || p == POS_MONTH || p == POS_DAY || p == POS_HOUR
            || p == POS_MINUTE || p == POS_SECOND)
            sh_ended = 1'b0;
        if (in_field && !sh_ended) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                if (p <= 3)                  sh_year   = YEAR_W'(sh_year * 10 + dv);
                else if (p == 5 || p == 6)   sh_month  = FIELD_W'(sh_month * 10 + dv);
                else if (p == 8 || p == 9)   sh_day    = FIELD_W'(sh_day * 10 + dv);
                else if (p == 11 || p == 12) sh_hour   = FIELD_W'(sh_hour * 10 + dv);
                else if (p == 14 || p == 15) sh_minute = FIELD_W'(sh_minute * 10 + dv);
                else                         sh_second = FIELD_W'(sh_second * 10 + dv);
            end else begin
                sh_ended = 1'b1;
            end
        end
        if (sh_pos < FULL_LEN) sh_pos = sh_pos + 1'b1;
        if (is_last) begin
            if (sh_pos < FULL_LEN || sh_year < sh_earliest || sh_month < 1 || sh_month > 12
                || sh_day < 1 || sh_day > 31) begin
                res.secs = '0;
                res.ok   = 1'b0;
            end else begin
                res.secs = stamp_seconds();
                res.ok   = 1'b1;
            end
            expected_epochs.push_back(res);
            clear_fields();
        end
    endtask

    // Send one character beat; valid stays up until the handshake.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_char <= c;
        i_last_char <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_char(c, is_last);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
            send_char(text_buf[k], k == text_buf.size() - 1);
        stamps_sent++;
    endtask

    task automatic load_text(input string s);
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    endtask

    task automatic send_string(input string s);
        load_text(s);
        send_text();
    endtask

    task automatic push_num(input int v, input int n);
        int div;
        div = 1;
        repeat (n - 1) div *= 10;
        repeat (n) begin
            text_buf.push_back(8'(CHAR_ZERO + (v / div) % 10));
            div /= 10;
        end
    endtask

    task automatic push_sep(input logic [7:0] c);
        if ($urandom_range(9) == 0) text_buf.push_back(8'($urandom_range(255)));
        else text_buf.push_back(c);
    endtask

    // Drain the pipeline, then write the earliest-year register.
    task automatic write_earliest(input logic [YEAR_W-1:0] v);
        i_in_valid <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sh_earliest = v;
    endtask

    function automatic int pick_year();
        int y;
        if ($urandom_range(1) == 0) return $urandom_range(1970, 9999);
        y = int'(sh_earliest) + $urandom_range(60) - 10;
        if (y < 1970) y = 1970;
        if (y > 9999) y = 9999;
        return y;
    endfunction

    // Mostly well-formed stamps with random content; some noise, corruption, truncation.
    task automatic build_random_stamp();
        int kind;
        kind = $urandom_range(99);
        text_buf.delete();
        if (kind < 6) begin
            repeat ($urandom_range(1, 30)) text_buf.push_back(8'($urandom_range(255)));
        end else begin
            push_num(pick_year(), 4);
            push_sep("-");
            push_num(($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12), 2);
            push_sep("-");
            push_num(($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 31), 2);
            push_sep("T");
            push_num($urandom_range(99), 2);
            push_sep(":");
            push_num($urandom_range(99), 2);
            push_sep(":");
            push_num($urandom_range(99), 2);
            case ($urandom_range(9))
                7:       ;
                8, 9:    repeat ($urandom_range(1, 15))
                             text_buf.push_back(8'($urandom_range(255)));
                default: text_buf.push_back("Z");
            endcase
            if ($urandom_range(9) == 0)
                text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
            if (kind >= 92) begin
                int cut;
                cut = $urandom_range(1, 18);
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end
        end
    endtask

    task automatic test_reset_earliest();
        send_string("2019-12-31T23:59:59Z");
        send_string("2020-01-01T00:00:00Z");
    endtask

    task automatic test_calendar();
        write_earliest(YEAR_EPOCH);
        send_string("1970-01-01T00:00:00Z");
        send_string("2000-02-29T12:34:56Z");
        send_string("2100-03-01T00:00:00");
        send_string("2038-01-19T03:14:08Z");
        send_string("9999-12-31T99:99:99Z");
    endtask

    task automatic test_rejects();
        send_string("1969-12-31T23:59:59Z");
        send_string("2021-00-10T01:02:03Z");
        send_string("2021-13-10T01:02:03Z");
        send_string("2021-06-00T01:02:03Z");
        send_string("2021-06-32T01:02:03Z");
        send_string("2021-06-15T10:20:3");
        send_string("Z");
    endtask

    task automatic test_odd_text();
        send_string("+021-06-15T10:20:30Z");
        send_string("2021- 6-15T10:20:30Z");
        send_string("2021-6x-15T1x:2-:3 Z");
        send_string("2024-02-29T10:20:30.123456789+00:00");
        // Separator slots carry arbitrary bytes and must be skipped.
        load_text("2024-12-31T23:59:59Z");
        text_buf[4]  = 8'hFF;
        text_buf[7]  = 8'h00;
        text_buf[10] = 8'hA5;
        text_buf[13] = 8'h5A;
        text_buf[16] = 8'h80;
        send_text();
    endtask

    task automatic test_random(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) begin
            build_random_stamp();
            send_text();
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        stamps_sent  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sh_earliest  = EARLIEST_RESET;
        clear_fields();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_text_char <= '0;
        i_last_char <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_earliest();
        test_calendar();
        test_rejects();
        test_odd_text();
        write_earliest(14'($urandom_range(1970, 9999)));
        test_random(16, 75, 14);
        write_earliest(14'd9999);
        test_random(75, 16, 14);
        write_earliest(YEAR_EPOCH);
        test_random(0, 0, 14);

        i_in_valid <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d timestamps over three idle mixes and four earliest-year settings;",
                 stamps_sent);
        $display("%0d results checked, %0d of them accepted conversions.", results_seen, ok_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire
